// File: hw/rtl/clfs_pkg.sv
// Shared constants, codes and types for the line follower steering block.
// No dependencies; every other file takes names from here by scope.
package clfs_pkg;

    localparam int SAMPLE_W    = 10;               // width of a sample field on the port
    localparam int SAMPLE_BITS = 10;               // bits of a sample that are used
    localparam int NCH         = 6;
    localparam int CH_W        = $clog2(NCH);
    localparam int LEVEL_W     = 7;
    localparam int LEVEL_MAX   = 100;
    localparam int DUTY_W      = 9;
    localparam int DUTY_TOP    = 256;
    localparam int CORR_W      = DUTY_W + 3;
    localparam int SUM_W       = DUTY_W + 4;

    // Normalizing divider: one quotient bit per step, quotient always below 128
    localparam int DIV_STEPS   = LEVEL_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int N_W         = SAMPLE_BITS + 1;
    localparam int DVD_W       = SAMPLE_BITS + DIV_STEPS;
    localparam int DVS_W       = SAMPLE_BITS + DIV_STEPS - 1;

    localparam logic [SAMPLE_BITS-1:0] SMASK = {SAMPLE_BITS{1'b1}};

    // Function codes
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_CAL   = 2'd1;
    localparam logic [1:0] FUNC_DRIVE = 2'd2;
    localparam logic [1:0] FUNC_START = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER     = 3'd4;

    localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 7'd30;
    localparam logic [DUTY_W-1:0]  BASE_RST      = 9'd102;
    localparam logic [DUTY_W-1:0]  OUTER_RST     = 9'd120;
    localparam logic [DUTY_W-1:0]  MIDDLE_RST    = 9'd10;
    localparam logic [DUTY_W-1:0]  INNER_RST     = 9'd3;

    // Channel-4 crosstalk fix, keyed on channel 3
    localparam int XT_REF_CH = 3;
    localparam int XT_FIX_CH = 4;
    localparam logic [LEVEL_W-1:0] XT_HI_LO  = 7'd50;
    localparam logic [LEVEL_W-1:0] XT_HI_HI  = 7'd75;
    localparam logic [LEVEL_W-1:0] XT_HI_VAL = 7'd20;
    localparam logic [LEVEL_W-1:0] XT_LO_LO  = 7'd10;
    localparam logic [LEVEL_W-1:0] XT_LO_HI  = 7'd15;
    localparam logic [LEVEL_W-1:0] XT_LO_VAL = 7'd75;

    typedef logic [NCH-1:0][SAMPLE_BITS-1:0] raw_vec_t;

    typedef struct packed {
        logic            load;
        logic            setup;
        logic            step;
        logic            last;
        logic            fix;
        logic            calc;
        logic            commit;
        logic [CH_W-1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       out_free;
    } sts_t;

endpackage

// File: hw/rtl/clfs_if.sv
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on clfs_pkg for field widths.
interface clfs_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic [clfs_pkg::SAMPLE_W-1:0] sample_0;
    logic [clfs_pkg::SAMPLE_W-1:0] sample_1;
    logic [clfs_pkg::SAMPLE_W-1:0] sample_2;
    logic [clfs_pkg::SAMPLE_W-1:0] sample_3;
    logic [clfs_pkg::SAMPLE_W-1:0] sample_4;
    logic [clfs_pkg::SAMPLE_W-1:0] sample_5;

    modport source (output valid, func, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, input ready);
    modport sink   (input valid, func, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, output ready);
endinterface

interface clfs_out_if;
    logic                        valid;
    logic                        ready;
    logic [clfs_pkg::DUTY_W-1:0] left_pwm;
    logic [clfs_pkg::DUTY_W-1:0] right_pwm;
    logic [clfs_pkg::NCH-1:0]    line_bits;
    logic                        line_lost;
    logic                        kickstart;

    modport source (output valid, left_pwm, right_pwm, line_bits, line_lost, kickstart,
                    input ready);
    modport sink   (input valid, left_pwm, right_pwm, line_bits, line_lost, kickstart,
                    output ready);
endinterface

interface clfs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [clfs_pkg::CFG_IDX_W-1:0]  index;
    logic [clfs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/clfs_ctrl.sv
// Sequencer: decode; drive items then per-channel normalize, fix, sum; then emit.
// Depends on clfs_pkg for the command and status structs.
module clfs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  clfs_pkg::sts_t sts,
    output clfs_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FIX    = 3'd4;
    localparam logic [2:0] S_CALC   = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic [clfs_pkg::CH_W-1:0]     ch_reg, ch_next;
    logic [clfs_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          last_step;

    assign in_ready  = (state_reg == S_IDLE);
    assign last_step = (step_reg == clfs_pkg::STEP_W'(clfs_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ch_next = '0;
                if (sts.func == clfs_pkg::FUNC_DRIVE)
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cmd.last = last_step;
                if (!last_step)
                begin
                    step_next = step_reg + 1'b1;
                end
                else if (ch_reg == clfs_pkg::CH_W'(clfs_pkg::NCH - 1))
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: hw/rtl/clfs_dp.sv
// Datapath: config and calibration registers, shared restoring divider,
// crosstalk fix, weighted steering sum and the output register. Uses clfs_pkg.
module clfs_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  clfs_pkg::cmd_t                    cmd,
    output clfs_pkg::sts_t                    sts,
    input  logic                              cfg_we,
    input  logic [clfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clfs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [1:0]                        in_func,
    input  clfs_pkg::raw_vec_t                in_raw,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [clfs_pkg::DUTY_W-1:0]       left_pwm,
    output logic [clfs_pkg::DUTY_W-1:0]       right_pwm,
    output logic [clfs_pkg::NCH-1:0]          line_bits,
    output logic                              line_lost,
    output logic                              kickstart
);

    localparam int NCH = clfs_pkg::NCH;
    localparam int SB  = clfs_pkg::SAMPLE_BITS;
    localparam int LW  = clfs_pkg::LEVEL_W;
    localparam int DW  = clfs_pkg::DUTY_W;
    localparam logic signed [clfs_pkg::SUM_W-1:0] DUTY_TOP_S =
        clfs_pkg::SUM_W'(clfs_pkg::DUTY_TOP);

    function automatic logic [DW-1:0] sat_duty(input logic signed [clfs_pkg::SUM_W-1:0] v);
        logic [DW-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > DUTY_TOP_S)
        begin
            r = DW'(clfs_pkg::DUTY_TOP);
        end
        else
        begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    // configuration
    logic [LW-1:0] thresh_reg, thresh_next;
    logic [DW-1:0] base_reg, base_next;
    logic [DW-1:0] outer_reg, outer_next;
    logic [DW-1:0] middle_reg, middle_next;
    logic [DW-1:0] inner_reg, inner_next;

    // block state
    logic [NCH-1:0][SB-1:0] min_reg, min_next;
    logic [NCH-1:0][SB-1:0] max_reg, max_next;
    logic [NCH-1:0][LW-1:0] level_reg, level_next;
    logic [DW-1:0]          last_left_reg, last_left_next;
    logic [DW-1:0]          last_right_reg, last_right_next;
    logic                   kick_armed_reg, kick_armed_next;

    // item and working registers
    logic [1:0]                          func_reg, func_next;
    clfs_pkg::raw_vec_t                  raw_reg, raw_next;
    logic [clfs_pkg::DVD_W-1:0]          rem_reg, rem_next;
    logic [clfs_pkg::DVS_W-1:0]          dvs_reg, dvs_next;
    logic [LW-1:0]                       quo_reg, quo_next;
    logic                                div_go_reg, div_go_next;
    logic [NCH-1:0]                      bits_reg, bits_next;
    logic signed [clfs_pkg::CORR_W-1:0]  corr_reg, corr_next;

    // output register
    logic           out_valid_reg, out_valid_next;
    logic [DW-1:0]  left_reg, left_next;
    logic [DW-1:0]  right_reg, right_next;
    logic [NCH-1:0] obits_reg, obits_next;
    logic           lost_reg, lost_next;
    logic           kick_reg, kick_next;

    // channel setup terms
    logic [SB-1:0]                     sel_raw, sel_min, sel_max;
    logic signed [clfs_pkg::N_W-1:0]   n_s, d_s;
    logic [SB-1:0]                     abs_n, abs_d;
    logic                              rem_ge;
    logic [NCH-1:0][DW-1:0]            wmag;
    logic signed [clfs_pkg::SUM_W-1:0] base_s, lsum, rsum;
    logic [LW-1:0]                     ref_level;

    assign sel_raw = raw_reg[cmd.ch];
    assign sel_min = min_reg[cmd.ch];
    assign sel_max = max_reg[cmd.ch];
    assign n_s     = signed'({1'b0, sel_raw}) - signed'({1'b0, sel_min});
    assign d_s     = signed'({1'b0, sel_max}) - signed'({1'b0, sel_min});
    assign abs_n   = n_s[clfs_pkg::N_W-1] ? SB'(-n_s) : SB'(n_s);
    assign abs_d   = d_s[clfs_pkg::N_W-1] ? SB'(-d_s) : SB'(d_s);
    assign rem_ge  = (rem_reg >= clfs_pkg::DVD_W'(dvs_reg));

    assign wmag[0] = outer_reg;
    assign wmag[1] = middle_reg;
    assign wmag[2] = inner_reg;
    assign wmag[3] = inner_reg;
    assign wmag[4] = middle_reg;
    assign wmag[5] = outer_reg;

    assign base_s    = clfs_pkg::SUM_W'(signed'({1'b0, base_reg}));
    assign lsum      = base_s + clfs_pkg::SUM_W'(corr_reg);
    assign rsum      = base_s - clfs_pkg::SUM_W'(corr_reg);
    assign ref_level = level_reg[clfs_pkg::XT_REF_CH];

    always_comb
    begin
        thresh_next = thresh_reg;
        base_next   = base_reg;
        outer_next  = outer_reg;
        middle_next = middle_reg;
        inner_next  = inner_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                clfs_pkg::CFG_THRESHOLD: thresh_next = cfg_data[LW-1:0];
                clfs_pkg::CFG_BASE:      base_next   = cfg_data;
                clfs_pkg::CFG_OUTER:     outer_next  = cfg_data;
                clfs_pkg::CFG_MIDDLE:    middle_next = cfg_data;
                clfs_pkg::CFG_INNER:     inner_next  = cfg_data;
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        func_next   = func_reg;
        raw_next    = raw_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        quo_next    = quo_reg;
        div_go_next = div_go_reg;
        level_next  = level_reg;
        bits_next   = bits_reg;
        corr_next   = corr_reg;

        if (cmd.load)
        begin
            func_next = in_func;
            raw_next  = in_raw;
        end

        if (cmd.setup)
        begin
            div_go_next = 1'b0;
            rem_next    = clfs_pkg::DVD_W'(abs_n) * clfs_pkg::DVD_W'(clfs_pkg::LEVEL_MAX);
            dvs_next    = clfs_pkg::DVS_W'(abs_d) << (clfs_pkg::DIV_STEPS - 1);
            quo_next    = '0;
            // equal min and max keeps the old level
            if (d_s != 0)
            begin
                if (n_s == 0 || (n_s[clfs_pkg::N_W-1] != d_s[clfs_pkg::N_W-1]))
                begin
                    level_next[cmd.ch] = '0;
                end
                else if (abs_n >= abs_d)
                begin
                    level_next[cmd.ch] = LW'(clfs_pkg::LEVEL_MAX);
                end
                else
                begin
                    div_go_next = 1'b1;
                end
            end
        end

        if (cmd.step)
        begin
            if (rem_ge)
            begin
                rem_next = rem_reg - clfs_pkg::DVD_W'(dvs_reg);
            end
            quo_next = {quo_reg[LW-2:0], rem_ge};
            dvs_next = dvs_reg >> 1;
            if (cmd.last && div_go_reg)
            begin
                level_next[cmd.ch] = {quo_reg[LW-2:0], rem_ge};
            end
        end

        if (cmd.fix)
        begin
            if (ref_level >= clfs_pkg::XT_HI_LO && ref_level <= clfs_pkg::XT_HI_HI)
            begin
                level_next[clfs_pkg::XT_FIX_CH] = clfs_pkg::XT_HI_VAL;
            end
            else if (ref_level >= clfs_pkg::XT_LO_LO && ref_level <= clfs_pkg::XT_LO_HI)
            begin
                level_next[clfs_pkg::XT_FIX_CH] = clfs_pkg::XT_LO_VAL;
            end
        end

        if (cmd.calc)
        begin
            corr_next = '0;
            for (int i = 0; i < NCH; i++)
            begin
                bits_next[i] = (level_reg[i] < thresh_reg);
                if (bits_next[i])
                begin
                    // left-hand sensors steer negative
                    if (i < NCH / 2)
                    begin
                        corr_next = corr_next - clfs_pkg::CORR_W'(signed'({1'b0, wmag[i]}));
                    end
                    else
                    begin
                        corr_next = corr_next + clfs_pkg::CORR_W'(signed'({1'b0, wmag[i]}));
                    end
                end
            end
        end
    end

    always_comb
    begin
        min_next        = min_reg;
        max_next        = max_reg;
        last_left_next  = last_left_reg;
        last_right_next = last_right_reg;
        kick_armed_next = kick_armed_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        left_next       = left_reg;
        right_next      = right_reg;
        obits_next      = obits_reg;
        lost_next       = lost_reg;
        kick_next       = kick_reg;

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            left_next      = '0;
            right_next     = '0;
            obits_next     = '0;
            lost_next      = 1'b0;
            kick_next      = 1'b0;
            unique case (func_reg)
                clfs_pkg::FUNC_CLEAR:
                begin
                    for (int i = 0; i < NCH; i++)
                    begin
                        min_next[i] = clfs_pkg::SMASK;
                        max_next[i] = '0;
                    end
                end
                clfs_pkg::FUNC_CAL:
                begin
                    for (int i = 0; i < NCH; i++)
                    begin
                        if (raw_reg[i] > max_reg[i])
                        begin
                            max_next[i] = raw_reg[i];
                        end
                        if (raw_reg[i] < min_reg[i])
                        begin
                            min_next[i] = raw_reg[i];
                        end
                    end
                end
                clfs_pkg::FUNC_START:
                begin
                    last_left_next  = '0;
                    last_right_next = '0;
                    kick_armed_next = 1'b1;
                end
                clfs_pkg::FUNC_DRIVE:
                begin
                    kick_next       = kick_armed_reg;
                    kick_armed_next = 1'b0;
                    obits_next      = bits_reg;
                    if (bits_reg == '0)
                    begin
                        // no line: repeat the last duties
                        lost_next  = 1'b1;
                        left_next  = last_left_reg;
                        right_next = last_right_reg;
                    end
                    else
                    begin
                        left_next       = sat_duty(lsum);
                        right_next      = sat_duty(rsum);
                        last_left_next  = sat_duty(lsum);
                        last_right_next = sat_duty(rsum);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg     <= clfs_pkg::THRESHOLD_RST;
            base_reg       <= clfs_pkg::BASE_RST;
            outer_reg      <= clfs_pkg::OUTER_RST;
            middle_reg     <= clfs_pkg::MIDDLE_RST;
            inner_reg      <= clfs_pkg::INNER_RST;
            for (int i = 0; i < NCH; i++)
            begin
                min_reg[i]   <= clfs_pkg::SMASK;
                max_reg[i]   <= '0;
                level_reg[i] <= '0;
            end
            last_left_reg  <= '0;
            last_right_reg <= '0;
            kick_armed_reg <= 1'b1;
            div_go_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            thresh_reg     <= thresh_next;
            base_reg       <= base_next;
            outer_reg      <= outer_next;
            middle_reg     <= middle_next;
            inner_reg      <= inner_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            level_reg      <= level_next;
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
            kick_armed_reg <= kick_armed_next;
            div_go_reg     <= div_go_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        raw_reg   <= raw_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        quo_reg   <= quo_next;
        bits_reg  <= bits_next;
        corr_reg  <= corr_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        obits_reg <= obits_next;
        lost_reg  <= lost_next;
        kick_reg  <= kick_next;
    end

    assign sts.func     = func_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign left_pwm  = left_reg;
    assign right_pwm = right_reg;
    assign line_bits = obits_reg;
    assign line_lost = lost_reg;
    assign kickstart = kick_reg;

endmodule

// File: hw/rtl/calibrated_line_follower_steering.sv
// Top level of the line follower steering block: controller plus datapath.
// Depends on clfs_pkg, the channel interfaces, clfs_ctrl and clfs_dp.
//
// Channels: in_ch takes one item (func code and six raw samples), out_ch
// gives exactly one result item per input item, cfg_ch writes a register
// by index (0 threshold, 1 base duty, 2..4 outer/middle/inner weight);
// other indexes are ignored. cfg_ch is always ready; write only while idle.
// Sequence: a clear, calibrate or start item passes through decode to the result
// load, and in_ch is ready again in the same cycle that its result becomes valid.
// A drive item passes through these steps: a decode step, then each of the six
// channels is normalized in turn on one shared restoring divider (a setup step
// plus seven quotient bits), then the crosstalk fix, the steering sum and the
// result load. in_ch is ready again once the result is loaded into the output
// register, so the next item is taken while the result waits on out_ch.
// Stalls: with out_ch stalled the result holds and a finished item waits in
// the controller until the output register frees up.
// Reset: config registers return to their defaults, calibration cleared (min all
// ones, max zero), levels and last duties zero, kickstart armed.
module calibrated_line_follower_steering (
    input  logic        clk,
    input  logic        rst_n,
    clfs_in_if.sink     in_ch,
    clfs_out_if.source  out_ch,
    clfs_cfg_if.sink    cfg_ch
);

    clfs_pkg::cmd_t     cmd;
    clfs_pkg::sts_t     sts;
    clfs_pkg::raw_vec_t in_raw;
    logic               in_ready;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = in_ready;

    assign in_raw[0] = clfs_pkg::SAMPLE_BITS'(in_ch.sample_0);
    assign in_raw[1] = clfs_pkg::SAMPLE_BITS'(in_ch.sample_1);
    assign in_raw[2] = clfs_pkg::SAMPLE_BITS'(in_ch.sample_2);
    assign in_raw[3] = clfs_pkg::SAMPLE_BITS'(in_ch.sample_3);
    assign in_raw[4] = clfs_pkg::SAMPLE_BITS'(in_ch.sample_4);
    assign in_raw[5] = clfs_pkg::SAMPLE_BITS'(in_ch.sample_5);

    clfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    clfs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_ch.valid),
        .cfg_index  (cfg_ch.index),
        .cfg_data   (cfg_ch.data),
        .in_func    (in_ch.func),
        .in_raw     (in_raw),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .left_pwm   (out_ch.left_pwm),
        .right_pwm  (out_ch.right_pwm),
        .line_bits  (out_ch.line_bits),
        .line_lost  (out_ch.line_lost),
        .kickstart  (out_ch.kickstart)
    );

endmodule

// File: hw/rtl/clfs_checker.sv
// Port-level checks for the steering block, attached to the top by bind.
// Depends on clfs_pkg for widths and the duty limit.
module clfs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [clfs_pkg::DUTY_W-1:0] left_pwm,
    input logic [clfs_pkg::DUTY_W-1:0] right_pwm,
    input logic [clfs_pkg::NCH-1:0]    line_bits,
    input logic                        line_lost,
    input logic                        kickstart
);

    localparam logic [clfs_pkg::DUTY_W-1:0] TOP = clfs_pkg::DUTY_W'(clfs_pkg::DUTY_TOP);

    logic       in_acc, out_acc;
    logic [1:0] pending_reg, pending_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // count items taken but not yet delivered
    always_comb
    begin
        pending_next = pending_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable({left_pwm, right_pwm, line_bits, line_lost, kickstart}))
        else $error("result changed or dropped while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 2'd0)
        else $error("result delivered with no item outstanding");

    a_one_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pending_reg <= 2'd1)
        else $error("item taken with two results still outstanding");

    a_lost_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_lost |-> line_bits == '0)
        else $error("line lost reported with line bits set");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_pwm <= TOP && right_pwm <= TOP)
        else $error("duty above full scale");

endmodule

bind calibrated_line_follower_steering clfs_checker u_clfs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .left_pwm   (out_ch.left_pwm),
    .right_pwm  (out_ch.right_pwm),
    .line_bits  (out_ch.line_bits),
    .line_lost  (out_ch.line_lost),
    .kickstart  (out_ch.kickstart)
);

// File: sim/tb_top.sv
// Testbench for calibrated_line_follower_steering: random and directed sensor items
// checked against an in-bench steering predictor. Depends on clfs_pkg and the
// channel interfaces clfs_in_if, clfs_out_if and clfs_cfg_if.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS      = 220;
    localparam int N_PHASES         = 8;
    localparam int TAIL_CYCLES      = 64;

    localparam int NCH       = clfs_pkg::NCH;
    localparam int SB        = clfs_pkg::SAMPLE_BITS;
    localparam int DW        = clfs_pkg::DUTY_W;
    localparam int LW        = clfs_pkg::LEVEL_W;
    localparam int DUTY_TOP  = clfs_pkg::DUTY_TOP;
    localparam int LEVEL_MAX = clfs_pkg::LEVEL_MAX;
    localparam int CFG_DW    = clfs_pkg::CFG_DATA_W;

    // Crosstalk windows on channel 3 and the level forced onto channel 4
    localparam int XT_A_LO  = 50;
    localparam int XT_A_HI  = 75;
    localparam int XT_A_SET = 20;
    localparam int XT_B_LO  = 10;
    localparam int XT_B_HI  = 15;
    localparam int XT_B_SET = 75;

    typedef struct packed {
        logic [1:0]         func;
        clfs_pkg::raw_vec_t smp;
    } sensor_item_t;

    typedef struct packed {
        logic [DW-1:0]  left_pwm;
        logic [DW-1:0]  right_pwm;
        logic [NCH-1:0] line_bits;
        logic           line_lost;
        logic           kickstart;
    } steer_res_t;

    logic clk = 1'b0;
    logic rst_n;

    clfs_in_if  in_ch();
    clfs_out_if out_ch();
    clfs_cfg_if cfg_ch();

    calibrated_line_follower_steering DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #5 clk = ~clk;

    // Predictor copy of registers and state
    logic [LW-1:0]  gain_thr;
    logic [DW-1:0]  gain_base;
    logic [DW-1:0]  gain_outer;
    logic [DW-1:0]  gain_middle;
    logic [DW-1:0]  gain_inner;
    logic [SB-1:0]  cal_lo[NCH];
    logic [SB-1:0]  cal_hi[NCH];
    int             chan_level[NCH];
    logic [DW-1:0]  held_left;
    logic [DW-1:0]  held_right;
    logic           kick_pending;

    sensor_item_t pending_items[$];
    steer_res_t   expected_steer[$];
    sensor_item_t cur_item;

    int  n_queued   = 0;
    int  n_accepted = 0;
    int  n_checked  = 0;
    int  errors     = 0;
    bit  idle_on    = 1'b1;
    int  hold_request = 0;
    int  hold_seen    = 0;
    int  hold_left    = 0;
    int  src_gap      = 0;
    int  sink_gap     = 0;
    bit  drv_offer;
    bit  sink_take;
    steer_res_t got_res;
    steer_res_t exp_res;

    function automatic logic [DW-1:0] clip_duty(int v);
        if (v < 0)
            return '0;
        if (v > DUTY_TOP)
            return DW'(DUTY_TOP);
        return DW'(v);
    endfunction

    function automatic steer_res_t predict_steering(sensor_item_t it);
        steer_res_t r;
        int num;
        int den;
        int q;
        int corr;
        int wt[NCH];
        logic [NCH-1:0] seen;
        r    = '0;
        corr = 0;
        seen = '0;
        case (it.func)
            clfs_pkg::FUNC_CLEAR: begin
                for (int ch = 0; ch < NCH; ch++)
                begin
                    cal_lo[ch] = '1;
                    cal_hi[ch] = '0;
                end
            end
            clfs_pkg::FUNC_CAL: begin
                for (int ch = 0; ch < NCH; ch++)
                begin
                    if (it.smp[ch] > cal_hi[ch])
                        cal_hi[ch] = it.smp[ch];
                    if (it.smp[ch] < cal_lo[ch])
                        cal_lo[ch] = it.smp[ch];
                end
            end
            clfs_pkg::FUNC_START: begin
                held_left    = '0;
                held_right   = '0;
                kick_pending = 1'b1;
            end
            default: begin
                for (int ch = 0; ch < NCH; ch++)
                begin
                    num = int'(it.smp[ch]) - int'(cal_lo[ch]);
                    den = int'(cal_hi[ch]) - int'(cal_lo[ch]);
                    // hold the old level on a zero-width window
                    if (den != 0)
                    begin
                        q = (LEVEL_MAX * num) / den;
                        if (q < 0)
                            q = 0;
                        if (q > LEVEL_MAX)
                            q = LEVEL_MAX;
                        chan_level[ch] = q;
                    end
                end
                if (chan_level[3] >= XT_A_LO && chan_level[3] <= XT_A_HI)
                    chan_level[4] = XT_A_SET;
                else if (chan_level[3] >= XT_B_LO && chan_level[3] <= XT_B_HI)
                    chan_level[4] = XT_B_SET;

                wt = '{-int'(gain_outer), -int'(gain_middle), -int'(gain_inner),
                       int'(gain_inner), int'(gain_middle), int'(gain_outer)};
                for (int ch = 0; ch < NCH; ch++)
                begin
                    if (chan_level[ch] < int'(gain_thr))
                    begin
                        seen[ch] = 1'b1;
                        corr += wt[ch];
                    end
                end
                r.kickstart  = kick_pending;
                kick_pending = 1'b0;
                if (seen == '0)
                begin
                    r.line_lost = 1'b1;
                    r.left_pwm  = held_left;
                    r.right_pwm = held_right;
                end
                else
                begin
                    r.left_pwm  = clip_duty(int'(gain_base) + corr);
                    r.right_pwm = clip_duty(int'(gain_base) - corr);
                    held_left   = r.left_pwm;
                    held_right  = r.right_pwm;
                end
                r.line_bits = seen;
            end
        endcase
        return r;
    endfunction

    // Driver: offer queued items, predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            drv_offer = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                expected_steer.push_back(predict_steering(cur_item));
                n_accepted++;
                drv_offer = 1'b0;
                if (idle_on && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 10);
            end
            if (!drv_offer)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_items.size() > 0)
                begin
                    cur_item = pending_items.pop_front();
                    drv_offer = 1'b1;
                    in_ch.func     <= cur_item.func;
                    in_ch.sample_0 <= cur_item.smp[0];
                    in_ch.sample_1 <= cur_item.smp[1];
                    in_ch.sample_2 <= cur_item.smp[2];
                    in_ch.sample_3 <= cur_item.smp[3];
                    in_ch.sample_4 <= cur_item.smp[4];
                    in_ch.sample_5 <= cur_item.smp[5];
                end
            end
            in_ch.valid <= drv_offer;
        end
    end

    task automatic check_field(string name, int want, int seen_val);
        if (want != seen_val)
        begin
            $error("%s: expected %0d, actual %0d", name, want, seen_val);
            errors++;
        end
    endtask

    // Monitor: check each result, stall the output at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                n_checked++;
                got_res.left_pwm  = out_ch.left_pwm;
                got_res.right_pwm = out_ch.right_pwm;
                got_res.line_bits = out_ch.line_bits;
                got_res.line_lost = out_ch.line_lost;
                got_res.kickstart = out_ch.kickstart;
                if (expected_steer.size() == 0)
                begin
                    $error("result with no item pending: left %0d right %0d bits %b",
                           got_res.left_pwm, got_res.right_pwm, got_res.line_bits);
                    errors++;
                end
                else
                begin
                    exp_res = expected_steer.pop_front();
                    check_field("left_pwm", exp_res.left_pwm, got_res.left_pwm);
                    check_field("right_pwm", exp_res.right_pwm, got_res.right_pwm);
                    check_field("line_bits", exp_res.line_bits, got_res.line_bits);
                    check_field("line_lost", exp_res.line_lost, got_res.line_lost);
                    check_field("kickstart", exp_res.kickstart, got_res.kickstart);
                end
            end
            if (hold_request != hold_seen)
            begin
                hold_seen = hold_request;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                sink_take = 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                sink_take = 1'b0;
            end
            else
            begin
                sink_take = 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 10);
            end
            out_ch.ready <= sink_take;
        end
    end

    function automatic clfs_pkg::raw_vec_t vec6(int a, int b, int c, int d, int e, int f);
        clfs_pkg::raw_vec_t v;
        v[0] = SB'(a);
        v[1] = SB'(b);
        v[2] = SB'(c);
        v[3] = SB'(d);
        v[4] = SB'(e);
        v[5] = SB'(f);
        return v;
    endfunction

    task automatic push_sensor_item(logic [1:0] f, clfs_pkg::raw_vec_t v);
        sensor_item_t it;
        it.func = f;
        it.smp  = v;
        pending_items.push_back(it);
        n_queued++;
    endtask

    function automatic int pick_sample(int lo, int hi);
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, clfs_pkg::SMASK);
            1: return lo;
            2: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // One run: optional clear, calibration sweep, optional start, drive samples
    task automatic queue_drive_run();
        int lo[NCH];
        int hi[NCH];
        int n_cal;
        int n_drv;
        clfs_pkg::raw_vec_t v;
        if ($urandom_range(0, 4) != 0)
            push_sensor_item(clfs_pkg::FUNC_CLEAR, vec6($urandom, $urandom, $urandom,
                                                        $urandom, $urandom, $urandom));
        for (int ch = 0; ch < NCH; ch++)
        begin
            lo[ch] = $urandom_range(0, clfs_pkg::SMASK);
            hi[ch] = ($urandom_range(0, 9) == 0) ? lo[ch] :
                     $urandom_range(lo[ch], clfs_pkg::SMASK);
        end
        n_cal = $urandom_range(2, 5);
        for (int k = 0; k < n_cal; k++)
        begin
            for (int ch = 0; ch < NCH; ch++)
                v[ch] = SB'((k == 0) ? lo[ch] : (k == 1) ? hi[ch] :
                            $urandom_range(lo[ch], hi[ch]));
            push_sensor_item(clfs_pkg::FUNC_CAL, v);
        end
        if ($urandom_range(0, 5) != 0)
            push_sensor_item(clfs_pkg::FUNC_START, vec6($urandom, $urandom, $urandom,
                                                        $urandom, $urandom, $urandom));
        n_drv = $urandom_range(5, 40);
        for (int k = 0; k < n_drv; k++)
        begin
            // noise: an arbitrary item dropped into the run
            if ($urandom_range(0, 9) == 0)
                push_sensor_item(2'($urandom), vec6($urandom, $urandom, $urandom,
                                                    $urandom, $urandom, $urandom));
            for (int ch = 0; ch < NCH; ch++)
                v[ch] = SB'(pick_sample(lo[ch], hi[ch]));
            push_sensor_item(clfs_pkg::FUNC_DRIVE, v);
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (n_accepted != n_queued || n_checked != n_accepted);
    endtask

    task automatic write_reg(logic [clfs_pkg::CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            clfs_pkg::CFG_THRESHOLD: gain_thr    = val[LW-1:0];
            clfs_pkg::CFG_BASE:      gain_base   = val;
            clfs_pkg::CFG_OUTER:     gain_outer  = val;
            clfs_pkg::CFG_MIDDLE:    gain_middle = val;
            clfs_pkg::CFG_INNER:     gain_inner  = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(int thr, int base, int outer, int middle, int inner);
        write_reg(clfs_pkg::CFG_THRESHOLD, CFG_DW'(thr));
        write_reg(clfs_pkg::CFG_BASE, CFG_DW'(base));
        write_reg(clfs_pkg::CFG_OUTER, CFG_DW'(outer));
        write_reg(clfs_pkg::CFG_MIDDLE, CFG_DW'(middle));
        write_reg(clfs_pkg::CFG_INNER, CFG_DW'(inner));
        // an index past the last register must change nothing
        write_reg(clfs_pkg::CFG_INNER + clfs_pkg::CFG_IDX_W'($urandom_range(1, 3)),
                  CFG_DW'($urandom));
    endtask

    initial
    begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        int base_phase;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.func     = clfs_pkg::FUNC_CLEAR;
        in_ch.sample_0 = '0;
        in_ch.sample_1 = '0;
        in_ch.sample_2 = '0;
        in_ch.sample_3 = '0;
        in_ch.sample_4 = '0;
        in_ch.sample_5 = '0;
        out_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = clfs_pkg::CFG_THRESHOLD;
        cfg_ch.data    = '0;

        gain_thr    = clfs_pkg::THRESHOLD_RST;
        gain_base   = clfs_pkg::BASE_RST;
        gain_outer  = clfs_pkg::OUTER_RST;
        gain_middle = clfs_pkg::MIDDLE_RST;
        gain_inner  = clfs_pkg::INNER_RST;
        for (int ch = 0; ch < NCH; ch++)
        begin
            cal_lo[ch]     = '1;
            cal_hi[ch]     = '0;
            chan_level[ch] = 0;
        end
        held_left    = '0;
        held_right   = '0;
        kick_pending = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: drive before any calibration (inverted window), then a flat window
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(0, 0, 0, 0, 0, 0));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 1023, 1023, 1023));
        push_sensor_item(clfs_pkg::FUNC_CAL, vec6(500, 500, 500, 500, 500, 500));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(12, 900, 345, 678, 1, 1000));
        push_sensor_item(clfs_pkg::FUNC_CLEAR, vec6(1023, 1023, 1023, 1023, 1023, 1023));
        push_sensor_item(clfs_pkg::FUNC_CAL, vec6(0, 0, 0, 0, 0, 0));
        push_sensor_item(clfs_pkg::FUNC_CAL, vec6(1023, 1023, 1023, 1023, 1023, 1023));
        push_sensor_item(clfs_pkg::FUNC_START,
                         vec6('h2AA, 'h155, 'h2AA, 'h155, 'h2AA, 'h155));
        // outermost sensors alone: saturate one wheel at zero
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(0, 1023, 1023, 1023, 1023, 1023));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 1023, 1023, 0));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 1023, 1023, 1023));
        // crosstalk windows and their edges on channel 3
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 614, 1023, 1023));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 123, 0, 1023));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 512, 1023, 1023));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 768, 1023, 1023));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 778, 0, 1023));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 103, 1023, 1023));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 154, 1023, 1023));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 164, 0, 1023));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 93, 1023, 1023));
        // start clears held duties: a lost line right after shows zeros
        push_sensor_item(clfs_pkg::FUNC_START, vec6(0, 0, 0, 0, 0, 0));
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 1023, 1023, 1023, 1023, 1023));
        // threshold edge: level 29 sees the line, level 30 does not
        push_sensor_item(clfs_pkg::FUNC_DRIVE, vec6(1023, 306, 307, 1023, 1023, 1023));
        push_sensor_item(clfs_pkg::FUNC_DRIVE,
                         vec6('h155, 'h2AA, 'h155, 'h2AA, 'h155, 'h2AA));
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            repeat (4) @(posedge clk);
            case (ph)
                0: load_settings(0, DUTY_TOP, DUTY_TOP, DUTY_TOP, DUTY_TOP);
                1: load_settings(LEVEL_MAX, 0, DUTY_TOP, DUTY_TOP, DUTY_TOP);
                2: load_settings(127, DUTY_TOP, 0, 0, 0);
                3: load_settings(50, 128, 200, 60, 15);
                7: load_settings(clfs_pkg::THRESHOLD_RST, clfs_pkg::BASE_RST,
                                 clfs_pkg::OUTER_RST, clfs_pkg::MIDDLE_RST,
                                 clfs_pkg::INNER_RST);
                default: load_settings({2'($urandom), 7'($urandom_range(0, LEVEL_MAX))},
                                       $urandom_range(0, DUTY_TOP),
                                       $urandom_range(0, DUTY_TOP),
                                       $urandom_range(0, DUTY_TOP),
                                       $urandom_range(0, DUTY_TOP));
            endcase
            idle_on = (ph != N_PHASES - 1);
            base_phase = n_queued;
            while (n_queued - base_phase < PHASE_ITEMS)
                queue_drive_run();
            // long output stall while items keep coming
            if (ph == 3)
                hold_request++;
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (expected_steer.size() != 0)
        begin
            $error("%0d results never arrived", expected_steer.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
